@@ hdl/tam_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tam_pkg
// Shared types and constants of the two-axis move controller: register
// layout, register indexes, status codes and drive levels.
// ----------------------------------------------------------------------------
package tam_pkg;

  localparam int unsigned POSITION_BITS_DEF = 10;
  localparam int unsigned CFG_W             = 10;
  localparam int unsigned TIMER_W           = 8;
  localparam int unsigned TARGET_W          = 12;
  localparam int unsigned DRIVE_W           = 8;
  localparam int unsigned STATUS_W          = 3;
  localparam int unsigned CFG_IDX_W         = 3;

  localparam logic signed [DRIVE_W-1:0] FULL_POWER    = 8'sd127;
  localparam logic signed [DRIVE_W-1:0] REDUCED_POWER = 8'sd32;

  localparam logic [CFG_W-1:0]   FOREARM_LOW_RST   = 10'd75;
  localparam logic [CFG_W-1:0]   FOREARM_HIGH_RST  = 10'd960;
  localparam logic [CFG_W-1:0]   SHOULDER_LOW_RST  = 10'd340;
  localparam logic [CFG_W-1:0]   SHOULDER_HIGH_RST = 10'd600;
  localparam logic [CFG_W-1:0]   FAR_BAND_RST      = 10'd60;
  localparam logic [CFG_W-1:0]   NEAR_BAND_RST     = 10'd3;
  localparam logic [TIMER_W-1:0] MOVE_TIMEOUT_RST  = 8'(4 * 38);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOREARM_LOW   = 3'd0,
    CFG_FOREARM_HIGH  = 3'd1,
    CFG_SHOULDER_LOW  = 3'd2,
    CFG_SHOULDER_HIGH = 3'd3,
    CFG_FAR_BAND      = 3'd4,
    CFG_NEAR_BAND     = 3'd5,
    CFG_MOVE_TIMEOUT  = 3'd6
  } tam_cfg_idx_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_IDLE    = 3'd0,
    ST_RUNNING = 3'd1,
    ST_SUCCESS = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_STARTED = 3'd4,
    ST_IGNORED = 3'd5
  } tam_status_e;

  typedef struct packed {
    logic [CFG_W-1:0]   forearm_low;
    logic [CFG_W-1:0]   forearm_high;
    logic [CFG_W-1:0]   shoulder_low;
    logic [CFG_W-1:0]   shoulder_high;
    logic [CFG_W-1:0]   far_band;
    logic [CFG_W-1:0]   near_band;
    logic [TIMER_W-1:0] move_timeout;
  } tam_cfg_t;

endpackage
`default_nettype wire

@@ hdl/tam_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tam_cfg_regs
// Configuration register file. Accepts one write beat per cycle and
// ignores writes to unused indexes.
// ----------------------------------------------------------------------------
module tam_cfg_regs
  import tam_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [CFG_W-1:0]      cfg_data_i,
  output tam_cfg_t              cfg_o
);

  tam_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (tam_cfg_idx_e'(cfg_index_i))
        CFG_FOREARM_LOW:   cfg_d.forearm_low   = cfg_data_i;
        CFG_FOREARM_HIGH:  cfg_d.forearm_high  = cfg_data_i;
        CFG_SHOULDER_LOW:  cfg_d.shoulder_low  = cfg_data_i;
        CFG_SHOULDER_HIGH: cfg_d.shoulder_high = cfg_data_i;
        CFG_FAR_BAND:      cfg_d.far_band      = cfg_data_i;
        CFG_NEAR_BAND:     cfg_d.near_band     = cfg_data_i;
        CFG_MOVE_TIMEOUT:  cfg_d.move_timeout  = cfg_data_i[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.forearm_low   <= FOREARM_LOW_RST;
      cfg_q.forearm_high  <= FOREARM_HIGH_RST;
      cfg_q.shoulder_low  <= SHOULDER_LOW_RST;
      cfg_q.shoulder_high <= SHOULDER_HIGH_RST;
      cfg_q.far_band      <= FAR_BAND_RST;
      cfg_q.near_band     <= NEAR_BAND_RST;
      cfg_q.move_timeout  <= MOVE_TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/tam_joint.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tam_joint
// Per-joint datapath: clamps a requested target and picks the start
// direction, and computes the banded drive and the arrival flag of a tick.
// ----------------------------------------------------------------------------
module tam_joint
  import tam_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire  signed [TARGET_W-1:0]  target_i,
  input  wire         [CFG_W-1:0]     low_i,
  input  wire         [CFG_W-1:0]     high_i,
  input  wire         [CFG_W-1:0]     far_band_i,
  input  wire         [CFG_W-1:0]     near_band_i,
  input  wire    [POSITION_BITS-1:0]  pos_i,
  input  wire    [POSITION_BITS-1:0]  setpoint_i,
  input  wire                         dir_up_i,
  input  wire                         arrived_i,
  input  wire                         upper_sw_i,
  input  wire                         lower_sw_i,
  output logic   [POSITION_BITS-1:0]  start_setpoint_o,
  output logic                        start_dir_up_o,
  output logic signed [DRIVE_W-1:0]   drive_o,
  output logic                        arrived_o
);

  localparam int unsigned MaxW  = (POSITION_BITS > CFG_W) ? POSITION_BITS : CFG_W;
  localparam int unsigned DistW = MaxW + 1;

  logic signed [TARGET_W-1:0] low_s, high_s, raised, clamped;
  logic [MaxW-1:0]            clamped_ext;
  logic signed [DistW-1:0]    diff;
  logic [DistW-1:0]           diff_abs;
  logic [MaxW-1:0]            mag_dist;
  logic signed [DRIVE_W-1:0]  mag;
  logic                       moving;

  assign low_s       = $signed({{(TARGET_W-CFG_W){1'b0}}, low_i});
  assign high_s      = $signed({{(TARGET_W-CFG_W){1'b0}}, high_i});
  assign raised      = (target_i < low_s) ? low_s : target_i;
  assign clamped     = (raised > high_s) ? high_s : raised;
  assign clamped_ext = MaxW'(clamped[CFG_W-1:0]);

  assign start_setpoint_o = clamped_ext[POSITION_BITS-1:0];
  assign start_dir_up_o   = pos_i < start_setpoint_o;

  assign diff     = $signed(DistW'(setpoint_i)) - $signed(DistW'(pos_i));
  assign diff_abs = diff[DistW-1] ? DistW'(-diff) : DistW'(diff);
  assign mag_dist = diff_abs[MaxW-1:0];
  assign moving   = !arrived_i && ((diff > 0) == dir_up_i);

  always_comb begin
    priority if (mag_dist > MaxW'(far_band_i)) begin
      mag = FULL_POWER;
    end else if (mag_dist > MaxW'(near_band_i)) begin
      mag = REDUCED_POWER;
    end else begin
      mag = '0;
    end
  end

  always_comb begin
    drive_o = '0;
    if (moving) begin
      drive_o = dir_up_i ? mag : -mag;
    end
  end

  assign arrived_o = (drive_o == '0) || (upper_sw_i && (drive_o > 0)) ||
                     (lower_sw_i && (drive_o < 0));

endmodule
`default_nettype wire

@@ hdl/two_axis_move_with_timeout.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A result is registered when its input beat leaves the input register.
// Throughput: one input beat per cycle; the input and result registers
// decouple the two channels, so the only stall comes from the output side.
// Reset clears the move state and both valid flags; configuration registers
// return to their documented defaults.
// ----------------------------------------------------------------------------
// two_axis_move_with_timeout
// Two-joint move controller with stepped drive, limit switch arrival and a
// tick timeout. Input register, combinational control logic, result register.
// ----------------------------------------------------------------------------
module two_axis_move_with_timeout
  import tam_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire         [CFG_IDX_W-1:0] cfg_index_i,
  input  wire         [CFG_W-1:0]     cfg_data_i,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire                         op_i,
  input  wire  signed [TARGET_W-1:0]  forearm_target_i,
  input  wire  signed [TARGET_W-1:0]  shoulder_target_i,
  input  wire    [POSITION_BITS-1:0]  forearm_pos_i,
  input  wire    [POSITION_BITS-1:0]  shoulder_pos_i,
  input  wire                         forearm_upper_sw_i,
  input  wire                         forearm_lower_sw_i,
  input  wire                         shoulder_upper_sw_i,
  input  wire                         shoulder_lower_sw_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic signed [DRIVE_W-1:0]   forearm_drive_o,
  output logic signed [DRIVE_W-1:0]   shoulder_drive_o,
  output logic        [STATUS_W-1:0]  status_o,
  output logic                        forearm_in_place_o,
  output logic                        shoulder_in_place_o
);

  tam_cfg_t cfg;

  logic                       in_vld_q, in_vld_d;
  logic                       op_q;
  logic signed [TARGET_W-1:0] ftgt_q, stgt_q;
  logic [POSITION_BITS-1:0]   fpos_q, spos_q;
  logic                       fup_q, flo_q, sup_q, slo_q;
  logic                       in_take, out_free, fire;

  logic                       busy_q, busy_d;
  logic [TIMER_W-1:0]         ticks_q, ticks_d;
  logic [POSITION_BITS-1:0]   fsp_q, fsp_d, ssp_q, ssp_d;
  logic                       fdir_q, fdir_d, sdir_q, sdir_d;
  logic                       farr_q, farr_d, sarr_q, sarr_d;

  logic [POSITION_BITS-1:0]   f_start_sp, s_start_sp;
  logic                       f_start_dir, s_start_dir;
  logic signed [DRIVE_W-1:0]  f_drive, s_drive;
  logic                       f_arr, s_arr;

  logic signed [DRIVE_W-1:0]  fd, sd;
  tam_status_e                status;

  logic                       out_vld_q, out_vld_d;
  logic signed [DRIVE_W-1:0]  out_fd_q, out_sd_q;
  tam_status_e                out_status_q;
  logic                       out_farr_q, out_sarr_q;

  tam_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tam_joint #(.POSITION_BITS(POSITION_BITS)) u_forearm (
    .target_i         (ftgt_q),
    .low_i            (cfg.forearm_low),
    .high_i           (cfg.forearm_high),
    .far_band_i       (cfg.far_band),
    .near_band_i      (cfg.near_band),
    .pos_i            (fpos_q),
    .setpoint_i       (fsp_q),
    .dir_up_i         (fdir_q),
    .arrived_i        (farr_q),
    .upper_sw_i       (fup_q),
    .lower_sw_i       (flo_q),
    .start_setpoint_o (f_start_sp),
    .start_dir_up_o   (f_start_dir),
    .drive_o          (f_drive),
    .arrived_o        (f_arr)
  );

  tam_joint #(.POSITION_BITS(POSITION_BITS)) u_shoulder (
    .target_i         (stgt_q),
    .low_i            (cfg.shoulder_low),
    .high_i           (cfg.shoulder_high),
    .far_band_i       (cfg.far_band),
    .near_band_i      (cfg.near_band),
    .pos_i            (spos_q),
    .setpoint_i       (ssp_q),
    .dir_up_i         (sdir_q),
    .arrived_i        (sarr_q),
    .upper_sw_i       (sup_q),
    .lower_sw_i       (slo_q),
    .start_setpoint_o (s_start_sp),
    .start_dir_up_o   (s_start_dir),
    .drive_o          (s_drive),
    .arrived_o        (s_arr)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    busy_d  = busy_q;
    ticks_d = ticks_q;
    fsp_d   = fsp_q;
    ssp_d   = ssp_q;
    fdir_d  = fdir_q;
    sdir_d  = sdir_q;
    farr_d  = farr_q;
    sarr_d  = sarr_q;
    fd      = '0;
    sd      = '0;
    status  = ST_IDLE;
    priority if (op_q) begin
      if (busy_q) begin
        status = ST_IGNORED;
      end else begin
        busy_d  = 1'b1;
        ticks_d = cfg.move_timeout;
        fsp_d   = f_start_sp;
        ssp_d   = s_start_sp;
        fdir_d  = f_start_dir;
        sdir_d  = s_start_dir;
        farr_d  = 1'b0;
        sarr_d  = 1'b0;
        status  = ST_STARTED;
      end
    end else if (!busy_q) begin
      status = ST_IDLE;
    end else if (ticks_q == '0) begin
      busy_d = 1'b0;
      status = ST_TIMEOUT;
    end else begin
      ticks_d = ticks_q - 1'b1;
      fd      = f_drive;
      sd      = s_drive;
      farr_d  = farr_q || f_arr;
      sarr_d  = sarr_q || s_arr;
      if (farr_d && sarr_d) begin
        busy_d = 1'b0;
        status = ST_SUCCESS;
      end else begin
        status = ST_RUNNING;
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      busy_q    <= 1'b0;
      ticks_q   <= '0;
      fsp_q     <= '0;
      ssp_q     <= '0;
      fdir_q    <= 1'b0;
      sdir_q    <= 1'b0;
      farr_q    <= 1'b0;
      sarr_q    <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (fire) begin
        busy_q  <= busy_d;
        ticks_q <= ticks_d;
        fsp_q   <= fsp_d;
        ssp_q   <= ssp_d;
        fdir_q  <= fdir_d;
        sdir_q  <= sdir_d;
        farr_q  <= farr_d;
        sarr_q  <= sarr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= op_i;
      ftgt_q <= forearm_target_i;
      stgt_q <= shoulder_target_i;
      fpos_q <= forearm_pos_i;
      spos_q <= shoulder_pos_i;
      fup_q  <= forearm_upper_sw_i;
      flo_q  <= forearm_lower_sw_i;
      sup_q  <= shoulder_upper_sw_i;
      slo_q  <= shoulder_lower_sw_i;
    end
    if (fire) begin
      out_fd_q     <= fd;
      out_sd_q     <= sd;
      out_status_q <= status;
      out_farr_q   <= farr_d;
      out_sarr_q   <= sarr_d;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign forearm_drive_o     = out_fd_q;
  assign shoulder_drive_o    = out_sd_q;
  assign status_o            = out_status_q;
  assign forearm_in_place_o  = out_farr_q;
  assign shoulder_in_place_o = out_sarr_q;

endmodule
`default_nettype wire
